// ----- src/dwipd_pkg.sv -----
// shared types and constants for the dual wheel incremental pid drive
package dwipd_pkg;

    // field widths
    localparam int ROAD_W     = 2;
    localparam int ERR_W      = 7;
    localparam int MAG_W      = 7;
    localparam int MEAS_W     = 16;
    localparam int SPEED_W    = 8;
    localparam int GAIN_W     = 16;
    localparam int DRIVE_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // datapath widths
    localparam int DIV_W   = 19;               // speed * 7 * 256
    localparam int TGT_W   = 20;               // base + steering quotient
    localparam int E_W     = 25;               // target - measured * 256
    localparam int OPA_W   = 27;               // widest error combination
    localparam int PROD_W  = OPA_W + GAIN_W + 1;
    localparam int SUM_W   = PROD_W + 2;
    localparam int BRAKE_W = 5;
    localparam int DCNT_W  = 5;

    // fixed constants of the control law
    localparam int ROAD_ORDINARY = 0;
    localparam int ROAD_HILL     = 3;
    localparam int STRAIGHT_BAND = 5;
    localparam int STEER_GAIN    = 7;
    localparam int BRAKE_LAST    = 20;
    localparam int REV_LEVEL_HI  = 40;
    localparam int REV_LEVEL_LO  = 10;

    // parameter defaults
    localparam int DEF_STRAIGHT_LIMIT = 400;
    localparam int DEF_DRIVE_MAX      = 200;

    // register reset values
    localparam logic [GAIN_W-1:0] RST_GAIN_PROP  = 16'd1536;
    localparam logic [GAIN_W-1:0] RST_GAIN_INTEG = 16'd512;
    localparam logic [GAIN_W-1:0] RST_GAIN_DERIV = 16'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_SPEED = 3'd0,
        CFG_BOOST_SPEED  = 3'd1,
        CFG_CLIMB_SPEED  = 3'd2,
        CFG_GAIN_PROP    = 3'd3,
        CFG_GAIN_INTEG   = 3'd4,
        CFG_GAIN_DERIV   = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        TERM_PROP  = 2'd0,
        TERM_DERIV = 2'd1,
        TERM_INTEG = 2'd2
    } t_term;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_TGT,
        S_DIF,
        S_MUL,
        S_ADD,
        S_UPD,
        S_OUT
    } t_state;

endpackage

// ----- src/dual_wheel_incremental_pid_drive.sv -----
// two-wheel incremental pid speed controller with a shared divider and multiplier
// steps in forward drive: the bit-serial divider, the error and error-difference
// registers, a multiply and an accumulate for each of six products, an accumulator
// update per wheel, then the output register; a zero lateral error skips the
// divider, reverse braking goes straight to the output register; a new item waits
// for the divider and the single 17x27 multiplier and for the result to be loaded
// reset (synchronous, active low): registers to defaults, accumulators,
// error history and tick counters cleared, no result pending
module dual_wheel_incremental_pid_drive #(
    parameter int STRAIGHT_LIMIT = dwipd_pkg::DEF_STRAIGHT_LIMIT,
    parameter int DRIVE_MAX      = dwipd_pkg::DEF_DRIVE_MAX
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [dwipd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [dwipd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input item channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [dwipd_pkg::ROAD_W-1:0]           i_road_type,
    input  logic signed [dwipd_pkg::ERR_W-1:0]     i_lateral_error,
    input  logic signed [dwipd_pkg::MEAS_W-1:0]    i_left_measured,
    input  logic signed [dwipd_pkg::MEAS_W-1:0]    i_right_measured,
    // result item channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_reverse,
    output logic [dwipd_pkg::DRIVE_W-1:0]          o_left_drive,
    output logic [dwipd_pkg::DRIVE_W-1:0]          o_right_drive
);

    // derived sizes
    localparam int ST_W    = $clog2(STRAIGHT_LIMIT + 1);
    localparam int ACC_MAX = DRIVE_MAX * 256;
    localparam int ACC_W   = $clog2(ACC_MAX + 1);
    localparam int NA_W    = dwipd_pkg::SUM_W - 8 + 1;
    localparam int SPEED_W = dwipd_pkg::SPEED_W;
    localparam int GAIN_W  = dwipd_pkg::GAIN_W;
    localparam int E_W     = dwipd_pkg::E_W;
    localparam int OPA_W   = dwipd_pkg::OPA_W;
    localparam int PROD_W  = dwipd_pkg::PROD_W;
    localparam int SUM_W   = dwipd_pkg::SUM_W;
    localparam int DIV_W   = dwipd_pkg::DIV_W;
    localparam int TGT_W   = dwipd_pkg::TGT_W;
    localparam int MAG_W   = dwipd_pkg::MAG_W;
    localparam int DRIVE_W = dwipd_pkg::DRIVE_W;
    localparam int BRAKE_W = dwipd_pkg::BRAKE_W;
    localparam int DCNT_W  = dwipd_pkg::DCNT_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [SPEED_W-1:0] r_normal_speed;
    logic [SPEED_W-1:0] r_boost_speed;
    logic [SPEED_W-1:0] r_climb_speed;
    logic [GAIN_W-1:0]  r_gain_prop;
    logic [GAIN_W-1:0]  r_gain_integ;
    logic [GAIN_W-1:0]  r_gain_deriv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_speed <= '0;
            r_boost_speed  <= '0;
            r_climb_speed  <= '0;
            r_gain_prop    <= dwipd_pkg::RST_GAIN_PROP;
            r_gain_integ   <= dwipd_pkg::RST_GAIN_INTEG;
            r_gain_deriv   <= dwipd_pkg::RST_GAIN_DERIV;
        end else if (i_cfg_we) begin
            // indexes past the register list are dropped
            case (i_cfg_idx)
                dwipd_pkg::CFG_NORMAL_SPEED: r_normal_speed <= i_cfg_data[SPEED_W-1:0];
                dwipd_pkg::CFG_BOOST_SPEED:  r_boost_speed  <= i_cfg_data[SPEED_W-1:0];
                dwipd_pkg::CFG_CLIMB_SPEED:  r_climb_speed  <= i_cfg_data[SPEED_W-1:0];
                dwipd_pkg::CFG_GAIN_PROP:    r_gain_prop    <= i_cfg_data;
                dwipd_pkg::CFG_GAIN_INTEG:   r_gain_integ   <= i_cfg_data;
                dwipd_pkg::CFG_GAIN_DERIV:   r_gain_deriv   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer state and registers
    // ------------------------------------------------------------------
    dwipd_pkg::t_state r_state, n_state;
    dwipd_pkg::t_term  r_term;
    logic              r_wheel;
    logic [DCNT_W-1:0] r_div_cnt;

    // per-item latched values
    logic                     r_rev;      // reverse braking for this item
    logic                     r_neg;      // steer boosts the left wheel
    logic                     r_pos;      // steer boosts the right wheel
    logic [SPEED_W-1:0]       r_speed;
    logic [MAG_W-1:0]         r_mag;
    logic signed [dwipd_pkg::MEAS_W-1:0] r_meas [2];

    // divider: r_quo shifts dividend bits out and quotient bits in
    logic [DIV_W-1:0] r_quo;
    logic [MAG_W-1:0] r_rem;

    // pid datapath
    logic signed [E_W-1:0]    r_e_cur [2];
    logic signed [E_W-1:0]    r_e1    [2];   // last error
    logic signed [E_W-1:0]    r_e2    [2];   // error before last
    logic signed [OPA_W-1:0]  r_d1    [2];   // e - e1
    logic signed [OPA_W-1:0]  r_d2    [2];   // e + e2 - 2*e1
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_sum;
    logic [ACC_W-1:0]         r_acc   [2];

    logic [ST_W-1:0]    r_straight;
    logic [BRAKE_W-1:0] r_brake;

    // result register
    logic               r_out_valid;
    logic               r_reverse;
    logic [DRIVE_W-1:0] r_left_drive;
    logic [DRIVE_W-1:0] r_right_drive;

    // ------------------------------------------------------------------
    // item acceptance: speed select and straight-stretch counter
    // ------------------------------------------------------------------
    logic               in_acc;
    logic [MAG_W-1:0]   mag_c;
    logic               straight_c;
    logic [ST_W:0]      st_inc_c;
    logic               st_sat_c;
    logic [ST_W-1:0]    st_next_c;
    logic [SPEED_W-1:0] speed_c;
    logic [DIV_W-1:0]   dividend_c;

    assign in_acc = i_in_valid && o_in_ready;

    always_comb begin
        mag_c      = i_lateral_error[dwipd_pkg::ERR_W-1] ?
                     MAG_W'(-i_lateral_error) : MAG_W'(i_lateral_error);
        straight_c = (i_road_type == dwipd_pkg::ROAD_W'(dwipd_pkg::ROAD_ORDINARY)) &&
                     (mag_c < MAG_W'(dwipd_pkg::STRAIGHT_BAND));
        st_inc_c   = {1'b0, r_straight} + (ST_W+1)'(1);
        st_sat_c   = st_inc_c >= (ST_W+1)'(STRAIGHT_LIMIT);
        if (!straight_c) begin
            st_next_c = '0;
        end else if (st_sat_c) begin
            st_next_c = ST_W'(STRAIGHT_LIMIT);
        end else begin
            st_next_c = st_inc_c[ST_W-1:0];
        end
        if (i_road_type == dwipd_pkg::ROAD_W'(dwipd_pkg::ROAD_HILL)) begin
            speed_c = r_climb_speed;
        end else if (straight_c && st_sat_c) begin
            speed_c = r_boost_speed;
        end else begin
            speed_c = r_normal_speed;
        end
        // speed * 7 in Q11.8
        dividend_c = {11'(speed_c * dwipd_pkg::STEER_GAIN), 8'd0};
    end

    // ------------------------------------------------------------------
    // divider step: one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [MAG_W:0] div_trial;
    logic           div_ge;
    always_comb begin
        div_trial = {r_rem, r_quo[DIV_W-1]};
        div_ge    = div_trial >= {1'b0, r_mag};
    end

    // ------------------------------------------------------------------
    // targets, errors and error combinations for both wheels
    // ------------------------------------------------------------------
    logic [SPEED_W+7:0]      base_c;
    logic [TGT_W-1:0]        tgt_c  [2];
    logic signed [E_W-1:0]   e_c    [2];
    logic signed [OPA_W-1:0] d1_c   [2];
    logic signed [OPA_W-1:0] d2_c   [2];

    always_comb begin
        base_c   = {r_speed, 8'd0};
        tgt_c[0] = TGT_W'(base_c) + (r_neg ? TGT_W'(r_quo) : '0);
        tgt_c[1] = TGT_W'(base_c) + (r_pos ? TGT_W'(r_quo) : '0);
        for (int w = 0; w < 2; w++) begin
            e_c[w]  = $signed({5'd0, tgt_c[w]}) - $signed({r_meas[w][15], r_meas[w], 8'd0});
            d1_c[w] = OPA_W'(r_e_cur[w]) - OPA_W'(r_e1[w]);
            d2_c[w] = OPA_W'(r_e_cur[w]) + OPA_W'(r_e2[w]) - (OPA_W'(r_e1[w]) <<< 1);
        end
    end

    // ------------------------------------------------------------------
    // shared multiplier: operand select per term and wheel
    // ------------------------------------------------------------------
    logic signed [OPA_W-1:0]  mul_a;
    logic signed [GAIN_W:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb begin
        case (r_term)
            dwipd_pkg::TERM_PROP: begin
                mul_a = r_d1[r_wheel];
                mul_b = $signed({1'b0, r_gain_prop});
            end
            dwipd_pkg::TERM_DERIV: begin
                mul_a = r_d2[r_wheel];
                mul_b = $signed({1'b0, r_gain_deriv});
            end
            dwipd_pkg::TERM_INTEG: begin
                mul_a = OPA_W'(r_e_cur[r_wheel]);
                mul_b = $signed({1'b0, r_gain_integ});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // accumulator update: floor to Q8.8, add, clamp
    logic signed [NA_W-1:0] na_c;
    logic [ACC_W-1:0]       acc_new_c;
    always_comb begin
        na_c = $signed({{(NA_W-ACC_W){1'b0}}, r_acc[r_wheel]}) + NA_W'(r_sum >>> 8);
        if (na_c < 0) begin
            acc_new_c = '0;
        end else if (na_c > $signed(NA_W'(ACC_MAX))) begin
            acc_new_c = ACC_W'(ACC_MAX);
        end else begin
            acc_new_c = na_c[ACC_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    logic out_load;
    assign out_load = (r_state == dwipd_pkg::S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            dwipd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (r_normal_speed == '0) begin
                        n_state = dwipd_pkg::S_OUT;
                    end else if (mag_c == '0) begin
                        n_state = dwipd_pkg::S_TGT;
                    end else begin
                        n_state = dwipd_pkg::S_DIV;
                    end
                end
            end
            dwipd_pkg::S_DIV: begin
                if (r_div_cnt == DCNT_W'(DIV_W - 1)) begin
                    n_state = dwipd_pkg::S_TGT;
                end
            end
            dwipd_pkg::S_TGT: n_state = dwipd_pkg::S_DIF;
            dwipd_pkg::S_DIF: n_state = dwipd_pkg::S_MUL;
            dwipd_pkg::S_MUL: n_state = dwipd_pkg::S_ADD;
            dwipd_pkg::S_ADD: begin
                n_state = (r_term == dwipd_pkg::TERM_INTEG) ? dwipd_pkg::S_UPD
                                                            : dwipd_pkg::S_MUL;
            end
            dwipd_pkg::S_UPD: begin
                n_state = r_wheel ? dwipd_pkg::S_OUT : dwipd_pkg::S_MUL;
            end
            dwipd_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = dwipd_pkg::S_IDLE;
                end
            end
            default: n_state = dwipd_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready    = (r_state == dwipd_pkg::S_IDLE);
        o_out_valid   = r_out_valid;
        o_reverse     = r_reverse;
        o_left_drive  = r_left_drive;
        o_right_drive = r_right_drive;
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dwipd_pkg::S_IDLE;
            r_term      <= dwipd_pkg::TERM_PROP;
            r_wheel     <= 1'b0;
            r_div_cnt   <= '0;
            r_straight  <= '0;
            r_brake     <= '0;
            r_out_valid <= 1'b0;
            for (int w = 0; w < 2; w++) begin
                r_acc[w] <= '0;
                r_e1[w]  <= '0;
                r_e2[w]  <= '0;
            end
        end else begin
            r_state <= n_state;

            if (in_acc) begin
                r_straight <= st_next_c;
                r_div_cnt  <= '0;
            end else if (r_state == dwipd_pkg::S_DIV) begin
                r_div_cnt <= r_div_cnt + DCNT_W'(1);
            end

            case (r_state)
                dwipd_pkg::S_DIF: begin
                    r_term  <= dwipd_pkg::TERM_PROP;
                    r_wheel <= 1'b0;
                end
                dwipd_pkg::S_ADD: begin
                    if (r_term != dwipd_pkg::TERM_INTEG) begin
                        r_term <= dwipd_pkg::t_term'(r_term + 2'd1);
                    end
                end
                dwipd_pkg::S_UPD: begin
                    // commit one wheel and shift its error history
                    r_acc[r_wheel] <= acc_new_c;
                    r_e2[r_wheel]  <= r_e1[r_wheel];
                    r_e1[r_wheel]  <= r_e_cur[r_wheel];
                    r_term         <= dwipd_pkg::TERM_PROP;
                    r_wheel        <= 1'b1;
                end
                default: ;
            endcase

            // brake counter saturates one past the high-level window
            if (out_load && r_rev && (r_brake <= BRAKE_W'(dwipd_pkg::BRAKE_LAST))) begin
                r_brake <= r_brake + BRAKE_W'(1);
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rev     <= (r_normal_speed == '0);
            r_neg     <= i_lateral_error < 0;
            r_pos     <= i_lateral_error > 0;
            r_speed   <= speed_c;
            r_mag     <= mag_c;
            r_meas[0] <= i_left_measured;
            r_meas[1] <= i_right_measured;
            r_rem     <= '0;
            // zero error skips the divider, steering term is zero
            r_quo     <= (mag_c == '0) ? '0 : dividend_c;
        end

        case (r_state)
            dwipd_pkg::S_DIV: begin
                r_rem <= div_ge ? MAG_W'(div_trial - {1'b0, r_mag}) : div_trial[MAG_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], div_ge};
            end
            dwipd_pkg::S_TGT: begin
                r_e_cur[0] <= e_c[0];
                r_e_cur[1] <= e_c[1];
            end
            dwipd_pkg::S_DIF: begin
                r_d1[0] <= d1_c[0];
                r_d1[1] <= d1_c[1];
                r_d2[0] <= d2_c[0];
                r_d2[1] <= d2_c[1];
                r_sum   <= '0;
            end
            dwipd_pkg::S_MUL: r_prod <= mul_p;
            dwipd_pkg::S_ADD: r_sum  <= r_sum + SUM_W'(r_prod);
            dwipd_pkg::S_UPD: r_sum  <= '0;
            default: ;
        endcase

        if (out_load) begin
            r_reverse <= r_rev;
            if (r_rev) begin
                r_left_drive  <= (r_brake <= BRAKE_W'(dwipd_pkg::BRAKE_LAST)) ?
                                 DRIVE_W'(dwipd_pkg::REV_LEVEL_HI) :
                                 DRIVE_W'(dwipd_pkg::REV_LEVEL_LO);
                r_right_drive <= (r_brake <= BRAKE_W'(dwipd_pkg::BRAKE_LAST)) ?
                                 DRIVE_W'(dwipd_pkg::REV_LEVEL_HI) :
                                 DRIVE_W'(dwipd_pkg::REV_LEVEL_LO);
            end else begin
                r_left_drive  <= DRIVE_W'(r_acc[0] >> 8);
                r_right_drive <= DRIVE_W'(r_acc[1] >> 8);
            end
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("block ready right after taking an item");

    a_acc_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc[0] <= ACC_W'(ACC_MAX)) && (r_acc[1] <= ACC_W'(ACC_MAX)))
        else $error("drive accumulator above clamp");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && (r_state == dwipd_pkg::S_IDLE)))
        else $error("result not posted on leaving output state");

    a_brake_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_brake <= BRAKE_W'(dwipd_pkg::BRAKE_LAST + 1))
        else $error("brake counter past saturation");

    a_straight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_straight <= ST_W'(STRAIGHT_LIMIT))
        else $error("straight counter past limit");

endmodule
